// ===== hw/rtl/frame_silence_detector_top_macros.svh =====
// Assertion macros for the frame silence detector.
`ifndef FRAME_SILENCE_DETECTOR_TOP_MACROS_SVH
`define FRAME_SILENCE_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the block clock, off during reset.
`define FSD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on the block clock, off during reset.
`define FSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FSD_ASSERT_IMPL(lbl, ante, cons)
`define FSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/fsd_pkg.sv =====
// Shared constants, types and codes of the frame silence detector.
`default_nettype none
package fsd_pkg;

    localparam int PROB_BITS  = 16;
    localparam int SCORE_W    = PROB_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(PROB_BITS + 2);
    localparam int OPND_W     = 32;
    localparam int ZCR_W      = 16;
    localparam int IDX_W      = 24;
    localparam int STEP_W     = 16;
    localparam int MAC_CNT_W  = $clog2(STEP_W + 1);
    localparam int POS_W      = 32;
    localparam int PROB_OUT_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    localparam logic [SCORE_W-1:0] ONE_Q  = SCORE_W'(1) << PROB_BITS;
    localparam logic [SCORE_W-1:0] HALF_Q = SCORE_W'(1) << (PROB_BITS - 1);

    localparam logic [OPND_W-1:0] ENERGY_THR_RST = 32'd1000;
    localparam logic [ZCR_W-1:0]  ZCR_THR_RST    = 16'd1000;
    localparam logic [STEP_W-1:0] FRAME_STEP_RST = 16'd160;
    localparam logic [STEP_W-1:0] FRAME_LEN_RST  = 16'd400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_THR,
        CFG_ZCR_THR,
        CFG_FRAME_STEP,
        CFG_FRAME_LEN
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ESTART,
        ST_EWAIT,
        ST_ZSTART,
        ST_ZWAIT,
        ST_SCORE,
        ST_POS,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/frame_silence_detector_top.sv =====
// Top level of the frame silence detector: control sequencer, scoring and output register.
//
//  channel   direction  handshake                 payload
//  s (frame) in         i_s_tvalid / o_s_tready   i_s_tdata, i_s_tlast
//  m (result) out       o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser
//  cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One frame passes through the shared divider, which yields one quotient bit per cycle for
// the energy score, then the zcr score.
// The frame position is multiplied bit-serially alongside the energy division.
// A new frame is taken as soon as the sequencer is idle, even while a result waits in the
// output register; a stalled output holds the sequencer in its last step only.
// Reset is synchronous and active low; it restores the register defaults and the frame counter.
`default_nettype none
`include "frame_silence_detector_top_macros.svh"
module frame_silence_detector_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Frame in, from bit 0: energy[31:0], zcr[47:32], segment_start[79:48].
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [fsd_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire logic                                i_s_tlast,
    // Result out, from bit 0: silence_probability[15:0], frame_first_sample[47:16],
    // frame_last_sample[79:48].
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic      [fsd_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // Result flag, from bit 0: silent[0].
    output logic      [0:0]                          o_m_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [fsd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [fsd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [fsd_pkg::OPND_W-1:0]     r_energy_thr;
    logic [fsd_pkg::ZCR_W-1:0]      r_zcr_thr;
    logic [fsd_pkg::STEP_W-1:0]     r_frame_step;
    logic [fsd_pkg::STEP_W-1:0]     r_frame_len;

    fsd_pkg::t_state                r_state;
    fsd_pkg::t_state                n_state;

    logic [fsd_pkg::IDX_W-1:0]      r_frame_index;
    logic [fsd_pkg::POS_W-1:0]      r_seg_base;
    logic                           r_last;
    logic [fsd_pkg::OPND_W-1:0]     r_energy;
    logic [fsd_pkg::ZCR_W-1:0]      r_zcr;
    logic                           r_e_below;
    logic                           r_z_below;
    logic                           r_e_dz;
    logic                           r_z_dz;
    logic [fsd_pkg::SCORE_W-1:0]    r_e_score;
    logic [fsd_pkg::SCORE_W-1:0]    r_z_score;
    logic [fsd_pkg::PROB_BITS-1:0]  r_prob;
    logic                           r_silent;
    logic [fsd_pkg::POS_W-1:0]      r_first;
    logic [fsd_pkg::POS_W-1:0]      r_len_m1;
    logic [fsd_pkg::POS_W-1:0]      r_lastsmp;

    logic                           r_out_valid;
    logic [fsd_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                           r_out_silent;

    logic                           s_accept;
    logic                           div_start;
    logic                           mac_start;
    logic                           out_load;
    logic [fsd_pkg::OPND_W-1:0]     div_a;
    logic [fsd_pkg::OPND_W-1:0]     div_d;
    fsd_pkg::t_div_stat             div_stat;
    logic [fsd_pkg::SCORE_W-1:0]    div_q;
    logic                           mac_busy;
    logic [fsd_pkg::POS_W-1:0]      mac_product;
    logic [fsd_pkg::SCORE_W-1:0]    score_sel;
    logic [fsd_pkg::SCORE_W-1:0]    score_min;
    logic [fsd_pkg::SCORE_W-1:0]    prob_sum;
    logic [fsd_pkg::PROB_BITS-1:0]  prob_sat;
    logic [fsd_pkg::PROB_BITS+fsd_pkg::PROB_OUT_W-1:0] prob_ext;
    logic [fsd_pkg::OPND_W-1:0]     in_energy;
    logic [fsd_pkg::ZCR_W-1:0]      in_zcr;
    logic [fsd_pkg::POS_W-1:0]      in_seg_start;
    logic [fsd_pkg::OPND_W-1:0]     zcr_ext;
    logic [fsd_pkg::OPND_W-1:0]     zthr_ext;

    assign in_energy    = i_s_tdata[31:0];
    assign in_zcr       = i_s_tdata[47:32];
    assign in_seg_start = i_s_tdata[79:48];
    assign zcr_ext      = fsd_pkg::OPND_W'(r_zcr);
    assign zthr_ext     = fsd_pkg::OPND_W'(r_zcr_thr);

    assign o_s_tready = (r_state == fsd_pkg::ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_thr <= fsd_pkg::ENERGY_THR_RST;
            r_zcr_thr    <= fsd_pkg::ZCR_THR_RST;
            r_frame_step <= fsd_pkg::FRAME_STEP_RST;
            r_frame_len  <= fsd_pkg::FRAME_LEN_RST;
        end else if (i_cfg_we) begin
            case (fsd_pkg::t_cfg_idx'(i_cfg_idx))
                fsd_pkg::CFG_ENERGY_THR: r_energy_thr <= i_cfg_data;
                fsd_pkg::CFG_ZCR_THR:    r_zcr_thr    <= i_cfg_data[fsd_pkg::ZCR_W-1:0];
                fsd_pkg::CFG_FRAME_STEP: r_frame_step <= i_cfg_data[fsd_pkg::STEP_W-1:0];
                fsd_pkg::CFG_FRAME_LEN:  r_frame_len  <= i_cfg_data[fsd_pkg::STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        mac_start = 1'b0;
        out_load  = 1'b0;
        div_a     = r_e_below ? r_energy : r_energy_thr;
        div_d     = r_e_below ? r_energy_thr : r_energy;
        case (r_state)
            fsd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    n_state = fsd_pkg::ST_ESTART;
                end
            end
            fsd_pkg::ST_ESTART: begin
                div_start = 1'b1;
                mac_start = 1'b1;
                n_state   = fsd_pkg::ST_EWAIT;
            end
            fsd_pkg::ST_EWAIT: begin
                if (div_stat.done) begin
                    n_state = fsd_pkg::ST_ZSTART;
                end
            end
            fsd_pkg::ST_ZSTART: begin
                div_a     = r_z_below ? zcr_ext : zthr_ext;
                div_d     = r_z_below ? zthr_ext : zcr_ext;
                div_start = 1'b1;
                n_state   = fsd_pkg::ST_ZWAIT;
            end
            fsd_pkg::ST_ZWAIT: begin
                if (div_stat.done) begin
                    n_state = fsd_pkg::ST_SCORE;
                end
            end
            fsd_pkg::ST_SCORE: begin
                n_state = fsd_pkg::ST_POS;
            end
            fsd_pkg::ST_POS: begin
                n_state = fsd_pkg::ST_OUT;
            end
            fsd_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = fsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsd_pkg::ST_IDLE;
            end
        endcase
    end

    fsd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_d     (div_d),
        .o_stat  (div_stat),
        .o_q     (div_q)
    );

    fsd_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mac_start),
        .i_index   (r_frame_index),
        .i_step    (r_frame_step),
        .o_busy    (mac_busy),
        .o_product (mac_product)
    );

    // Below its threshold a feature scores ONE minus the quotient; otherwise the quotient,
    // except that zero over zero scores zero.
    always_comb begin
        if (r_state == fsd_pkg::ST_EWAIT) begin
            score_sel = r_e_below ? (fsd_pkg::ONE_Q - div_q) : (r_e_dz ? '0 : div_q);
        end else begin
            score_sel = r_z_below ? (fsd_pkg::ONE_Q - div_q) : (r_z_dz ? '0 : div_q);
        end
        score_min = (r_e_score < r_z_score) ? r_e_score : r_z_score;
        prob_sum  = (score_min >> 1) + ((r_e_below && r_z_below) ? fsd_pkg::HALF_Q : '0);
        prob_sat  = prob_sum[fsd_pkg::PROB_BITS] ? '1 : prob_sum[fsd_pkg::PROB_BITS-1:0];
        prob_ext  = {{fsd_pkg::PROB_OUT_W{1'b0}}, r_prob};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_index <= '0;
            r_seg_base    <= '0;
        end else begin
            if (s_accept && (r_frame_index == '0)) begin
                r_seg_base <= in_seg_start;
            end
            if (r_state == fsd_pkg::ST_POS) begin
                r_frame_index <= r_last ? '0 : r_frame_index + fsd_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_energy  <= in_energy;
            r_zcr     <= in_zcr;
            r_last    <= i_s_tlast;
            r_e_below <= in_energy < r_energy_thr;
            r_z_below <= in_zcr < r_zcr_thr;
            r_e_dz    <= (in_energy == '0) && (r_energy_thr == '0);
            r_z_dz    <= (in_zcr == '0) && (r_zcr_thr == '0);
        end
        if (div_stat.done && (r_state == fsd_pkg::ST_EWAIT)) begin
            r_e_score <= score_sel;
        end
        if (div_stat.done && (r_state == fsd_pkg::ST_ZWAIT)) begin
            r_z_score <= score_sel;
        end
        if (r_state == fsd_pkg::ST_SCORE) begin
            r_prob   <= prob_sat;
            r_silent <= r_e_below && r_z_below;
            r_first  <= r_seg_base + mac_product;
            r_len_m1 <= fsd_pkg::POS_W'(r_frame_len) - fsd_pkg::POS_W'(1);
        end
        if (r_state == fsd_pkg::ST_POS) begin
            r_lastsmp <= r_first + r_len_m1;
        end
        if (out_load) begin
            r_out_data   <= {r_lastsmp, r_first, prob_ext[fsd_pkg::PROB_OUT_W-1:0]};
            r_out_silent <= r_silent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_silent;

    `FSD_ASSERT_NEXT(a_accept_starts_div, s_accept, r_state == fsd_pkg::ST_ESTART)
    `FSD_ASSERT_IMPL(a_done_in_wait, div_stat.done, r_state == fsd_pkg::ST_EWAIT || r_state == fsd_pkg::ST_ZWAIT)
    `FSD_ASSERT_IMPL(a_mac_idle_at_score, r_state == fsd_pkg::ST_SCORE, !mac_busy && !div_stat.busy)
    `FSD_ASSERT_NEXT(a_load_sets_valid, out_load, o_m_tvalid)

endmodule
`default_nettype wire

// ===== hw/rtl/fsd_div.sv =====
// Restoring divider producing one quotient bit per cycle: floor(a * 2^PROB_BITS / d), a <= d.
`default_nettype none
module fsd_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [fsd_pkg::OPND_W-1:0]        i_a,
    input  wire logic [fsd_pkg::OPND_W-1:0]        i_d,
    output fsd_pkg::t_div_stat                     o_stat,
    output logic      [fsd_pkg::SCORE_W-1:0]       o_q
);

    logic [fsd_pkg::OPND_W:0]          r_rem;
    logic [fsd_pkg::OPND_W-1:0]        r_div;
    logic [fsd_pkg::SCORE_W-1:0]       r_q;
    logic [fsd_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic                              r_busy;
    logic                              r_done;
    logic [fsd_pkg::OPND_W+1:0]        diff;
    logic                              ge;
    logic [fsd_pkg::OPND_W:0]          rsel;

    // The remainder never exceeds the divisor, so its doubled value fits.
    always_comb begin
        diff = {1'b0, r_rem} - {2'b00, r_div};
        ge   = ~diff[fsd_pkg::OPND_W+1];
        rsel = ge ? diff[fsd_pkg::OPND_W:0] : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= fsd_pkg::DIV_CNT_W'(fsd_pkg::SCORE_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - fsd_pkg::DIV_CNT_W'(1);
                if (r_cnt == fsd_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_a};
            r_div <= i_d;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= {rsel[fsd_pkg::OPND_W-1:0], 1'b0};
            r_q   <= {r_q[fsd_pkg::SCORE_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_q         = r_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fsd_mac.sv =====
// Bit-serial multiplier for frame_index * frame_step, step bits taken MSB first, modulo 2^32.
`default_nettype none
module fsd_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fsd_pkg::IDX_W-1:0]     i_index,
    input  wire logic [fsd_pkg::STEP_W-1:0]    i_step,
    output logic                               o_busy,
    output logic      [fsd_pkg::POS_W-1:0]     o_product
);

    logic [fsd_pkg::STEP_W-1:0]     r_step_sr;
    logic [fsd_pkg::IDX_W-1:0]      r_index;
    logic [fsd_pkg::POS_W-1:0]      r_acc;
    logic [fsd_pkg::MAC_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic [fsd_pkg::POS_W-1:0]      addend;

    assign addend = r_step_sr[fsd_pkg::STEP_W-1] ? fsd_pkg::POS_W'(r_index) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= fsd_pkg::MAC_CNT_W'(fsd_pkg::STEP_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - fsd_pkg::MAC_CNT_W'(1);
            if (r_cnt == fsd_pkg::MAC_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step_sr <= i_step;
            r_index   <= i_index;
            r_acc     <= '0;
        end else if (r_busy) begin
            r_step_sr <= {r_step_sr[fsd_pkg::STEP_W-2:0], 1'b0};
            r_acc     <= {r_acc[fsd_pkg::POS_W-2:0], 1'b0} + addend;
        end
    end

    assign o_busy    = r_busy;
    assign o_product = r_acc;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the frame silence detector with a scoring predictor.
module testbench;

    localparam longint unsigned UNIT_Q        = 64'd1 << fsd_pkg::PROB_BITS;
    localparam int unsigned     CYCLE_LIMIT   = 400000;
    localparam int unsigned     SETTLE_CYCLES = 50;
    localparam int unsigned     HOLD_AT       = 120;
    localparam int unsigned     HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [31:0] energy;
        logic [15:0] zcr;
        logic [31:0] seg_start;
        logic        last;
    } t_frame;

    typedef struct packed {
        logic        silent;
        logic [15:0] prob;
        logic [31:0] first;
        logic [31:0] last;
    } t_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_tvalid = 1'b0;
    logic                           o_s_tready;
    // energy[31:0], zcr[47:32], segment_start[79:48]
    logic [fsd_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                           i_s_tlast = 1'b0;
    logic                           o_m_tvalid;
    logic                           i_m_tready = 1'b0;
    // silence_probability[15:0], frame_first_sample[47:16], frame_last_sample[79:48]
    logic [fsd_pkg::OUT_DATA_W-1:0] o_m_tdata;
    // silent[0]
    logic [0:0]                     o_m_tuser;
    logic                           i_cfg_we = 1'b0;
    logic [fsd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [fsd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_silence_detector_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor copy of the registers and of the frame counter.
    logic [31:0] thr_energy = fsd_pkg::ENERGY_THR_RST;
    logic [15:0] thr_zcr    = fsd_pkg::ZCR_THR_RST;
    logic [15:0] step_len   = fsd_pkg::FRAME_STEP_RST;
    logic [15:0] frame_len  = fsd_pkg::FRAME_LEN_RST;
    logic [23:0] frame_idx  = '0;
    logic [31:0] seg_base   = '0;

    t_frame      frame_q[$];
    t_result     pending_results[$];
    t_frame      offer;
    t_result     want_res;
    bit          s_taken = 0;
    bit          calm = 0;
    bit          hold_done = 0;
    int unsigned s_gap = 0;
    int unsigned rx_gap = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned frames_sent = 0;
    int unsigned results_seen = 0;
    int unsigned silent_seen = 0;
    int unsigned settings_used = 1;
    int unsigned errors = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned feature_score(input longint unsigned v,
                                                      input longint unsigned t);
        if (v < t) return UNIT_Q - (v * UNIT_Q) / t;
        if (v == 0) return 0;
        return (t * UNIT_Q) / v;
    endfunction

    // Works out the result of one frame and advances the frame counter.
    function automatic t_result predict_frame(input t_frame f);
        t_result         r;
        longint unsigned es;
        longint unsigned zs;
        longint unsigned p;
        logic [63:0]     pos;
        if (frame_idx == 0) seg_base = f.seg_start;
        r.silent = (f.energy < thr_energy) && (f.zcr < thr_zcr);
        es = feature_score(f.energy, thr_energy);
        zs = feature_score(f.zcr, thr_zcr);
        p = ((es < zs) ? es : zs) >> 1;
        if (r.silent) p += UNIT_Q >> 1;
        if (p > UNIT_Q - 1) p = UNIT_Q - 1;
        r.prob = 16'(p);
        pos = 64'(seg_base) + 64'(frame_idx) * 64'(step_len);
        r.first = pos[31:0];
        r.last = r.first + 32'(frame_len) - 32'd1;
        frame_idx = f.last ? 24'd0 : frame_idx + 24'd1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at result %0d: %s", results_seen, what);
    endtask

    task automatic write_reg(input fsd_pkg::t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            fsd_pkg::CFG_ENERGY_THR: thr_energy = val;
            fsd_pkg::CFG_ZCR_THR:    thr_zcr = val[15:0];
            fsd_pkg::CFG_FRAME_STEP: step_len = val[15:0];
            fsd_pkg::CFG_FRAME_LEN:  frame_len = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_frame(input logic [31:0] e, input logic [15:0] z,
                              input logic [31:0] s, input logic l);
        frame_q.push_back('{e, z, s, l});
    endtask

    // Waits until every frame is taken and every result is back, then lets the block settle.
    task automatic drain();
        while (frame_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_energy();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return (thr_energy == 0) ? $urandom : $urandom_range(thr_energy - 1, 0);
            2: return thr_energy + $urandom_range(0, 6) - 3;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    function automatic logic [15:0] pick_zcr();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return (thr_zcr == 0) ? 16'($urandom) : 16'($urandom_range(thr_zcr - 1, 0));
            2: return thr_zcr + 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom_range(0, 3000));
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] e;
        logic [15:0] z;
        logic [15:0] st;
        logic [15:0] ln;
        case ($urandom_range(0, 7))
            0: e = 32'd0;
            1: e = 32'hFFFF_FFFF;
            2: e = $urandom;
            default: e = $urandom_range(1, 50000);
        endcase
        case ($urandom_range(0, 7))
            0: z = 16'd0;
            1: z = 16'hFFFF;
            2: z = 16'($urandom);
            default: z = 16'($urandom_range(1, 3000));
        endcase
        case ($urandom_range(0, 5))
            0: st = 16'd0;
            1: st = 16'hFFFF;
            default: st = 16'($urandom_range(1, 1000));
        endcase
        case ($urandom_range(0, 5))
            0: ln = 16'd0;
            1: ln = 16'hFFFF;
            default: ln = 16'($urandom_range(1, 2000));
        endcase
        // Upper bits of the narrow registers carry junk; the block must drop them.
        write_reg(fsd_pkg::CFG_ENERGY_THR, e);
        write_reg(fsd_pkg::CFG_ZCR_THR, {16'($urandom), z});
        write_reg(fsd_pkg::CFG_FRAME_STEP, {16'($urandom), st});
        write_reg(fsd_pkg::CFG_FRAME_LEN, {16'($urandom), ln});
        settings_used++;
    endtask

    // Mostly well-formed segments, with the odd flipped end marker.
    task automatic queue_segments(input int unsigned count);
        int unsigned seg_len;
        int unsigned i;
        logic        lst;
        while (count > 0) begin
            seg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 10);
            for (i = 0; i < seg_len && count > 0; i++) begin
                lst = (i == seg_len - 1);
                if ($urandom_range(0, 24) == 0) lst = ~lst;
                push_frame(pick_energy(), pick_zcr(), $urandom, lst);
                count--;
            end
        end
    endtask

    // Sender: holds each transaction until it is taken, with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_taken)) begin
            if (s_gap > 0) begin
                s_gap--;
                i_s_tvalid <= 1'b0;
            end else if (frame_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
                s_gap = $urandom_range(0, 17);
                i_s_tvalid <= 1'b0;
            end else if (frame_q.size() > 0) begin
                offer = frame_q.pop_front();
                i_s_tdata <= {offer.seg_start, offer.zcr, offer.energy};
                i_s_tlast <= offer.last;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off, counted in cycles, so the block backs up.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && frames_sent >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES;
            end
        end
    end

    // Receiver: random stall bursts, and no acceptance while the hold-off runs.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 17);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted frame and checks each accepted result.
    always @(posedge i_clk) begin
        s_taken = 0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                s_taken = 1;
                pending_results.push_back(predict_frame(offer));
                frames_sent++;
            end
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no frame outstanding");
                end else begin
                    want_res = pending_results.pop_front();
                    if (o_m_tuser[0] !== want_res.silent)
                        report_mismatch($sformatf("silent %b, expected %b",
                                                  o_m_tuser[0], want_res.silent));
                    if (o_m_tdata[15:0] !== want_res.prob)
                        report_mismatch($sformatf("probability %0d, expected %0d",
                                                  o_m_tdata[15:0], want_res.prob));
                    if (o_m_tdata[47:16] !== want_res.first)
                        report_mismatch($sformatf("first sample %0d, expected %0d",
                                                  o_m_tdata[47:16], want_res.first));
                    if (o_m_tdata[79:48] !== want_res.last)
                        report_mismatch($sformatf("last sample %0d, expected %0d",
                                                  o_m_tdata[79:48], want_res.last));
                    if (want_res.silent) silent_seen++;
                end
                results_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: scores around the thresholds and segment handling.
        push_frame(32'd0, 16'd0, 32'd0, 1'b0);
        push_frame(32'd999, 16'd999, 32'hDEAD_BEEF, 1'b0);
        push_frame(32'd1000, 16'd1000, 32'h1234_5678, 1'b0);
        push_frame(32'd1000, 16'd0, 32'd7, 1'b0);
        push_frame(32'hFFFF_FFFF, 16'hFFFF, 32'd9, 1'b1);
        push_frame(32'd0, 16'd500, 32'hFFFF_FFFF, 1'b0);
        push_frame(32'd500, 16'd0, 32'd3, 1'b0);
        push_frame(32'd1, 16'd1001, 32'd4, 1'b1);
        push_frame(32'd2000, 16'd2000, 32'd12345, 1'b1);
        drain();

        // Zero thresholds, zero step and zero length.
        write_reg(fsd_pkg::CFG_ENERGY_THR, 32'd0);
        write_reg(fsd_pkg::CFG_ZCR_THR, 32'd0);
        write_reg(fsd_pkg::CFG_FRAME_STEP, 32'd0);
        write_reg(fsd_pkg::CFG_FRAME_LEN, 32'd0);
        settings_used++;
        push_frame(32'd0, 16'd0, 32'hAAAA_5555, 1'b0);
        push_frame(32'd7, 16'd0, 32'd1, 1'b0);
        push_frame(32'd0, 16'd9, 32'd2, 1'b1);
        drain();

        // Largest thresholds, step and length.
        write_reg(fsd_pkg::CFG_ENERGY_THR, 32'hFFFF_FFFF);
        write_reg(fsd_pkg::CFG_ZCR_THR, 32'h0000_FFFF);
        write_reg(fsd_pkg::CFG_FRAME_STEP, 32'h0000_FFFF);
        write_reg(fsd_pkg::CFG_FRAME_LEN, 32'h0000_FFFF);
        settings_used++;
        push_frame(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_0000, 1'b0);
        push_frame(32'hFFFF_FFFE, 16'hFFFE, 32'd0, 1'b0);
        push_frame(32'd0, 16'd0, 32'd0, 1'b0);
        push_frame(32'h8000_0000, 16'h8000, 32'd0, 1'b0);
        push_frame(32'h1234_5678, 16'd1, 32'd0, 1'b1);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            random_settings();
            queue_segments(100);
            drain();
        end

        // Closing stretch runs at full rate on both sides.
        calm = 1;
        random_settings();
        queue_segments(60);
        drain();

        $display("Sent %0d frames under %0d register settings; checked %0d results, %0d silent.",
                 frames_sent, settings_used, results_seen, silent_seen);
        $display("Receiver hold-off applied: %0d, mismatches: %0d", hold_done, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
